@@ src/luma_hc_pkg.sv @@
// ----------------------------------------------------------------------------
// luma_hc_pkg
// shared types and constants of the luma highlight compression unit
// ----------------------------------------------------------------------------
`default_nettype none

package luma_hc_pkg;

    localparam int CH_W         = 32;
    localparam int NUM_LANES    = 3;
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STEPS    = 32;
    localparam int LANE_STAGES  = DIV_STEPS + 2;
    localparam int CFG_IDX_W    = 8;

    localparam logic [CH_W-1:0] CH_MAX = '1;

    // rec.709 weights in units of 2^-16
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;
    localparam logic [47:0] LUMA_RND = 48'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_LEVEL = 8'd1;

    typedef logic [NUM_LANES-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t      ch;
        logic [63:0] num;
        logic        num_neg;
        logic        den_neg;
        logic        dzero;
        logic        pass;
        logic [64:0] div;
    } front_t;

    typedef struct packed {
        logic            pass;
        logic            dzero;
        logic            force0;
        logic            ovf;
        logic [CH_W-1:0] ch;
    } lane_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            sat;
        logic            compressed;
    } lane_res_t;

    typedef lane_res_t [NUM_LANES-1:0] lane_res_arr_t;

endpackage

`default_nettype wire

@@ src/luma_hc_front.sv @@
// ----------------------------------------------------------------------------
// luma_hc_front
// luma, threshold test, numerator and divisor of the scale ratio (5 stages)
// ----------------------------------------------------------------------------
`default_nettype none

module luma_hc_front
    import luma_hc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire pixel_t          ch_in,
    input  wire logic [CH_W-1:0] thr,
    input  wire logic [CH_W-1:0] lvl,
    output front_t               fr
);

    logic [NUM_LANES-1:0][47:0] prod_a_reg;
    pixel_t ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [CH_W-1:0] luma_b_reg, luma_c_reg, luma_d_reg;
    logic [63:0] sq_c_reg, cl_c_reg;
    logic [32:0] dneg_c_reg;
    logic        pass_c_reg, pass_d_reg;
    logic [63:0] num_d_reg;
    logic        num_neg_d_reg, den_neg_d_reg;
    logic [32:0] dmag_d_reg;
    front_t      fr_reg;

    logic [47:0] sum_b;
    logic [32:0] dpos_d;

    assign sum_b  = prod_a_reg[0] + prod_a_reg[1] + prod_a_reg[2] + LUMA_RND;
    assign dpos_d = {thr, 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            // weighted products
            prod_a_reg[0] <= 48'(ch_in[0]) * 48'(W_RED);
            prod_a_reg[1] <= 48'(ch_in[1]) * 48'(W_GREEN);
            prod_a_reg[2] <= 48'(ch_in[2]) * 48'(W_BLUE);
            ch_a_reg      <= ch_in;
            // rounded luma
            luma_b_reg    <= sum_b[47:16];
            ch_b_reg      <= ch_a_reg;
            // squares and sums
            sq_c_reg      <= 64'(thr) * 64'(thr);
            cl_c_reg      <= 64'(lvl) * 64'(luma_b_reg);
            dneg_c_reg    <= 33'(lvl) + 33'(luma_b_reg);
            pass_c_reg    <= luma_b_reg <= thr;
            luma_c_reg    <= luma_b_reg;
            ch_c_reg      <= ch_b_reg;
            // magnitudes and signs
            num_neg_d_reg <= sq_c_reg < cl_c_reg;
            num_d_reg     <= (sq_c_reg < cl_c_reg) ? cl_c_reg - sq_c_reg
                                                   : sq_c_reg - cl_c_reg;
            den_neg_d_reg <= dpos_d < dneg_c_reg;
            dmag_d_reg    <= (dpos_d < dneg_c_reg) ? dneg_c_reg - dpos_d
                                                   : dpos_d - dneg_c_reg;
            pass_d_reg    <= pass_c_reg;
            luma_d_reg    <= luma_c_reg;
            ch_d_reg      <= ch_c_reg;
            // divisor
            fr_reg.div     <= 65'(dmag_d_reg) * 65'(luma_d_reg);
            fr_reg.num     <= num_d_reg;
            fr_reg.num_neg <= num_neg_d_reg;
            fr_reg.den_neg <= den_neg_d_reg;
            fr_reg.dzero   <= dmag_d_reg == 33'd0;
            fr_reg.pass    <= pass_d_reg;
            fr_reg.ch      <= ch_d_reg;
        end
    end

    assign fr = fr_reg;

endmodule

`default_nettype wire

@@ src/luma_hc_lane.sv @@
// ----------------------------------------------------------------------------
// luma_hc_lane
// one channel: product with the numerator, overflow test, pipelined divider
// ----------------------------------------------------------------------------
`default_nettype none

module luma_hc_lane
    import luma_hc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [CH_W-1:0] ch,
    input  wire front_t          fr,
    output lane_res_t            res
);

    logic [63:0] plo_reg, phi_reg;
    logic [64:0] div1_reg;
    lane_ctl_t   ctl1_reg;

    logic [95:0]     rem_reg [0:DIV_STEPS];
    logic [64:0]     div_reg [0:DIV_STEPS];
    logic [CH_W-1:0] q_reg   [0:DIV_STEPS];
    lane_ctl_t       ctl_reg [0:DIV_STEPS];

    logic [95:0]     rem_next [0:DIV_STEPS-1];
    logic [CH_W-1:0] q_next   [0:DIV_STEPS-1];

    logic [95:0] sum2;
    lane_ctl_t   ctl2;

    assign sum2 = {32'd0, plo_reg} + {phi_reg, 32'd0};

    always_comb begin
        ctl2     = ctl1_reg;
        ctl2.ovf = {1'b0, sum2} >= {div1_reg, 32'd0};
    end

    always_comb begin
        logic [96:0] d;
        for (int k = 0; k < DIV_STEPS; k++) begin
            d = 97'(div_reg[k]) << (DIV_STEPS - 1 - k);
            rem_next[k] = rem_reg[k];
            q_next[k]   = q_reg[k];
            if ({1'b0, rem_reg[k]} >= d) begin
                rem_next[k] = 96'({1'b0, rem_reg[k]} - d);
                q_next[k][DIV_STEPS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg         <= 64'(ch) * 64'(fr.num[31:0]);
            phi_reg         <= 64'(ch) * 64'(fr.num[63:32]);
            div1_reg        <= fr.div;
            ctl1_reg.pass   <= fr.pass;
            ctl1_reg.dzero  <= fr.dzero;
            ctl1_reg.force0 <= fr.num_neg != fr.den_neg;
            ctl1_reg.ovf    <= 1'b0;
            ctl1_reg.ch     <= ch;

            rem_reg[0] <= sum2;
            div_reg[0] <= div1_reg;
            q_reg[0]   <= '0;
            ctl_reg[0] <= ctl2;
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem_reg[k+1] <= rem_next[k];
                div_reg[k+1] <= div_reg[k];
                q_reg[k+1]   <= q_next[k];
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    always_comb begin
        lane_ctl_t c;
        c = ctl_reg[DIV_STEPS];
        res.compressed = !c.pass;
        res.sat        = !c.pass && (c.dzero || (!c.force0 && c.ovf));
        if (c.pass) begin
            res.value = c.ch;
        end else if (c.dzero) begin
            res.value = CH_MAX;
        end else if (c.force0) begin
            res.value = '0;
        end else if (c.ovf) begin
            res.value = CH_MAX;
        end else begin
            res.value = q_reg[DIV_STEPS];
        end
    end

endmodule

`default_nettype wire

@@ src/luma_hc_merge.sv @@
// ----------------------------------------------------------------------------
// luma_hc_merge
// combines the lane results into one output word and its flags
// ----------------------------------------------------------------------------
`default_nettype none

module luma_hc_merge
    import luma_hc_pkg::*;
(
    input  wire lane_res_arr_t res,
    output pixel_t             pix,
    output logic               was_compressed,
    output logic               saturated
);

    always_comb begin
        saturated = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            pix[i]    = res[i].value;
            saturated = saturated | res[i].sat;
        end
        was_compressed = res[0].compressed;
    end

endmodule

`default_nettype wire

@@ src/luma_highlight_compress_unit.sv @@
// ----------------------------------------------------------------------------
// luma_highlight_compress_unit
// highlight compression of hdr rgb pixels by their rec.709 luma
// ----------------------------------------------------------------------------
// s_ channel: one pixel per word, s_tdata = red, green, blue (32 bits each).
// m_ channel: one result word per pixel, m_tdata = red, green, blue,
// m_tuser = was_compressed, saturated.
// cfg channel: cfg_index 0 writes the linear threshold, 1 the compressed
// level; other indexes are ignored. cfg_ready is always high; write only
// while no pixel is in flight.
// throughput: one pixel per cycle while the output does not stall, through a
// fully pipelined path: 5 luma/ratio stages, then three channel lanes each
// with a product stage, an overflow stage and a 32-step restoring divider,
// one quotient bit per stage, then the output register.
// when m_tready is low with a word waiting, the whole pipeline holds,
// bubbles included, and s_tready drops.
// reset empties the pipeline and loads both levels with their defaults
// (4096 and 16384 in the channel format, saturated).
// ----------------------------------------------------------------------------
`default_nettype none

module luma_highlight_compress_unit
    import luma_hc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [95:0]          s_tdata,   // red_in, green_in, blue_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [95:0]               m_tdata,   // red_out, green_out, blue_out
    output logic [1:0]                m_tuser,   // was_compressed, saturated
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CH_W-1:0]      cfg_data
);

    localparam int LAT = FRONT_STAGES + LANE_STAGES;
    localparam logic [63:0] THR_WIDE = 64'd4096 << FRAC_BITS;
    localparam logic [63:0] LVL_WIDE = 64'd16384 << FRAC_BITS;
    localparam logic [CH_W-1:0] THR_RST =
        (THR_WIDE > 64'(CH_MAX)) ? CH_MAX : THR_WIDE[CH_W-1:0];
    localparam logic [CH_W-1:0] LVL_RST =
        (LVL_WIDE > 64'(CH_MAX)) ? CH_MAX : LVL_WIDE[CH_W-1:0];

    logic [CH_W-1:0] thr_reg, lvl_reg;
    logic [LAT-1:0]  vld_reg;
    logic            m_tvalid_reg;
    logic [95:0]     m_tdata_reg;
    logic [1:0]      m_tuser_reg;
    logic            en;

    pixel_t        ch_in, pix;
    front_t        fr;
    lane_res_arr_t res;
    logic          was_compressed, saturated;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign ch_in     = s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RST;
            lvl_reg <= LVL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LINEAR_THRESHOLD: thr_reg <= cfg_data;
                CFG_COMPRESSED_LEVEL: lvl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    luma_hc_front u_front (
        .aclk  (aclk),
        .en    (en),
        .ch_in (ch_in),
        .thr   (thr_reg),
        .lvl   (lvl_reg),
        .fr    (fr)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        luma_hc_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .ch   (fr.ch[i]),
            .fr   (fr),
            .res  (res[i])
        );
    end

    luma_hc_merge u_merge (
        .res            (res),
        .pix            (pix),
        .was_compressed (was_compressed),
        .saturated      (saturated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= pix;
            m_tuser_reg <= {saturated, was_compressed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ src/luma_hc_checker.sv @@
// ----------------------------------------------------------------------------
// luma_hc_checker
// port-level checks of the luma highlight compression unit
// ----------------------------------------------------------------------------
`default_nettype none

module luma_hc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_ready
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled word changed");

    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("saturated without compression");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready && cfg_ready)
        else $error("input stalled with free output");

endmodule

bind luma_highlight_compress_unit luma_hc_checker u_luma_hc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

@@ dv/tb_luma_highlight_compress_unit.sv @@
// ----------------------------------------------------------------------------
// tb_luma_highlight_compress_unit
// self-checking bench of the luma highlight compression unit: a fixed point
// predictor computes each expected pixel, results are compared in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_luma_highlight_compress_unit;
    import luma_hc_pkg::*;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        compressed;
        logic        sat;
    } pixel_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CH_W-1:0] cfg_data = '0;

    logic [31:0] lin_thr;
    logic [31:0] comp_lvl;
    pixel_res_t pending_q[$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    bit stall_mode = 1'b0;

    luma_highlight_compress_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] scale_lane(logic [31:0] c, logic [63:0] num,
                                               logic [127:0] div, output bit ovf);
        logic [127:0] prod;
        logic [127:0] q;
        prod = 128'(c) * 128'(num);
        q = prod / div;
        ovf = q > 128'hFFFF_FFFF;
        return ovf ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic pixel_res_t compress_pixel(logic [31:0] r, logic [31:0] g,
                                                  logic [31:0] b);
        pixel_res_t res;
        logic [63:0] luma, sq, cl, num, dpos, dneg, dmag;
        logic [127:0] div;
        logic [31:0] ch[3];
        bit num_neg, den_neg, ovf, sat;
        ch[0] = r; ch[1] = g; ch[2] = b;
        sat = 0;
        luma = (64'd13933 * r + 64'd46871 * g + 64'd4732 * b + 64'd32768) >> 16;
        res = '0;
        if (luma <= 64'(lin_thr)) begin
            res.red = r; res.green = g; res.blue = b;
            return res;
        end
        res.compressed = 1'b1;
        sq = 64'(lin_thr) * 64'(lin_thr);
        cl = 64'(comp_lvl) * luma;
        num_neg = sq < cl;
        num = num_neg ? cl - sq : sq - cl;
        dpos = 64'(lin_thr) << 1;
        dneg = 64'(comp_lvl) + luma;
        den_neg = dpos < dneg;
        dmag = den_neg ? dneg - dpos : dpos - dneg;
        if (dmag == 0) begin
            res.red = '1; res.green = '1; res.blue = '1; res.sat = 1'b1;
            return res;
        end
        div = 128'(dmag) * 128'(luma);
        for (int k = 0; k < 3; k++) begin
            if (num == 0 || ch[k] == 0 || num_neg != den_neg) ch[k] = 0;
            else begin
                ch[k] = scale_lane(ch[k], num, div, ovf);
                sat |= ovf;
            end
        end
        res.red = ch[0]; res.green = ch[1]; res.blue = ch[2]; res.sat = sat;
        return res;
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin
        pixel_res_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", m_tdata[31:0], 32'h0);
            end else begin
                exp_px = pending_q.pop_front();
                if (m_tdata[31:0] !== exp_px.red) report("red", m_tdata[31:0], exp_px.red);
                if (m_tdata[63:32] !== exp_px.green)
                    report("green", m_tdata[63:32], exp_px.green);
                if (m_tdata[95:64] !== exp_px.blue)
                    report("blue", m_tdata[95:64], exp_px.blue);
                if (m_tuser[0] !== exp_px.compressed)
                    report("was_compressed", m_tuser[0], exp_px.compressed);
                if (m_tuser[1] !== exp_px.sat) report("saturated", m_tuser[1], exp_px.sat);
            end
        end
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_LINEAR_THRESHOLD) lin_thr = val;
        else if (idx == CFG_COMPRESSED_LEVEL) comp_lvl = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // valid stays high after a word until the next gap or drain
    task automatic send_pixel(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                              input bit bursty);
        int gap;
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 30);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        pending_q.push_back(compress_pixel(r, g, b));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 32'h0;
            3: return 32'(lin_thr) + $urandom_range(0, 65535);
            default: return $urandom_range(0, 32'h4000_0000);
        endcase
    endfunction

    task automatic test_directed();
        @(negedge aclk);
        send_pixel(0, 0, 0, 0);
        send_pixel('1, '1, '1, 0);
        send_pixel('1, 0, 0, 0);
        send_pixel(0, '1, 0, 0);
        send_pixel(0, 0, '1, 0);
        send_pixel(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 0);
        send_pixel(32'h1000_0001, 32'h1000_0001, 32'h1000_0001, 0);
        send_pixel(32'h3000_0000, 0, 32'h3000_0000, 0);
        // negative numerator and denominator: 2L < C + luma
        send_pixel(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0);
        drain();
        // negative ratio, zero denominator and full-scale level settings
        write_reg(CFG_LINEAR_THRESHOLD, 32'h0000_0001);
        write_reg(CFG_COMPRESSED_LEVEL, 32'h0);
        send_pixel(32'h10, 32'h10, 32'h10, 0);
        send_pixel('1, '1, '1, 0);
        send_pixel(32'h5, 0, 32'h7, 0);
        drain();
        write_reg(CFG_LINEAR_THRESHOLD, 32'h0);
        write_reg(CFG_COMPRESSED_LEVEL, 32'hFFFF_FFFF);
        send_pixel(32'h10, 32'h20, 32'h30, 0);
        send_pixel('1, '1, '1, 0);
        drain();
        write_reg(8'hFF, 32'h1234_5678);
        write_reg(CFG_LINEAR_THRESHOLD, 32'hFFFF_FFFF);
        send_pixel('1, '1, '1, 0);
        drain();
    endtask

    task automatic test_random_phase(input logic [31:0] thr, input logic [31:0] lvl, input int n);
        write_reg(CFG_LINEAR_THRESHOLD, thr);
        write_reg(CFG_COMPRESSED_LEVEL, lvl);
        repeat (n) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1);
        drain();
    endtask

    initial begin
        lin_thr = 32'h1000_0000;
        comp_lvl = 32'h4000_0000;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_phase(32'h1000_0000, 32'h4000_0000, 400);
        test_random_phase(32'h0000_0000, 32'h0000_0000, 250);
        test_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
        test_random_phase($urandom(), $urandom(), 400);
        test_random_phase($urandom_range(0, 32'h0100_0000), $urandom(), 380);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
